// ===== hdl/sbbs_pkg.sv =====
package sbbs_pkg;

    // quotient bits of the angle divider (angle magnitude below 2**14)
    localparam int unsigned QW = 14;
    // product of angle limit and distance
    localparam int unsigned NW = 26;

    typedef enum logic [2:0] {
        CFG_CONTROL_MODE    = 3'd0,
        CFG_ERROR_SIGN      = 3'd1,
        CFG_MAX_ANGLE       = 3'd2,
        CFG_LEFT_POSITION   = 3'd3,
        CFG_RIGHT_POSITION  = 3'd4,
        CFG_MIDDLE_POSITION = 3'd5,
        CFG_DEAD_BAND       = 3'd6
    } t_cfg_idx;

    localparam logic [1:0] MODE_BANG  = 2'd0;
    localparam logic [1:0] MODE_OPEN  = 2'd1;
    localparam logic [1:0] MODE_PID   = 2'd2;
    localparam logic [1:0] MODE_OTHER = 2'd3;

    localparam logic signed [1:0] DRV_POS  = 2'sd1;
    localparam logic signed [1:0] DRV_NEG  = -2'sd1;
    localparam logic signed [1:0] DRV_STOP = 2'sd0;

    typedef struct packed {
        logic [1:0]         control_mode;
        logic signed [1:0]  error_sign;
        logic [6:0]         max_angle;
        logic [11:0]        left_position;
        logic [11:0]        right_position;
        logic [11:0]        middle_position;
        logic [9:0]         dead_band;
    } t_cfg;

    // result fields that ride alongside the divider
    typedef struct packed {
        logic signed [1:0]  drive;
        logic [11:0]        target;
        logic               over;
        logic               clamp;
        logic signed [14:0] clamp_val;
        logic               neg;
    } t_item;

    typedef struct packed {
        logic [NW-1:0] num;
        logic [11:0]   den;
        logic [11:0]   rem;
        logic [QW-1:0] quo;
    } t_div;

endpackage

// ===== hdl/sbbs_front.sv =====
module sbbs_front
    import sbbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_vld,
    input  logic signed [16:0] i_cmd,
    input  logic [11:0]        i_pos,
    input  t_cfg               i_cfg,
    output logic               o_vld,
    output t_item              o_item,
    output t_div               o_div
);

    // ---------------- stage 1: target product, segment choice ----------------
    logic               sat;
    logic [14:0]        k;
    logic [11:0]        base;
    logic signed [12:0] diff;
    logic signed [29:0] prod;
    logic signed [29:0] tgt;
    logic [13:0]        amax;
    logic signed [13:0] lim_lo, lim_hi;
    logic               lr, below, nz_a, nz_neg, swp, nz_lo;
    logic [11:0]        xa, xb, xlo, xhi;
    logic signed [14:0] nz_val;

    logic               r1_vld;
    logic [26:0]        r1_tgt;
    logic [11:0]        r1_pos;
    logic signed [1:0]  r1_csgn;
    logic               r1_over, r1_clamp, r1_neg;
    logic signed [14:0] r1_cval;
    logic [11:0]        r1_dist, r1_den;

    logic               n1_clamp;
    logic signed [14:0] n1_cval;
    logic [11:0]        n1_dist;

    assign sat  = i_cmd[16] ^ i_cmd[15];
    assign k    = sat ? 15'd0 : i_cmd[14:0];
    assign base = i_cmd[16] ? i_cfg.left_position
                            : (sat ? i_cfg.right_position : i_cfg.middle_position);
    assign diff = i_cmd[16]
        ? $signed({1'b0, i_cfg.middle_position}) - $signed({1'b0, i_cfg.left_position})
        : $signed({1'b0, i_cfg.right_position}) - $signed({1'b0, i_cfg.middle_position});
    assign prod = 30'($signed({1'b0, k}) * diff);
    assign tgt  = $signed({3'b0, base, 15'b0}) + prod;

    assign amax   = 14'(i_cfg.max_angle * 7'd100);
    assign lim_lo = $signed({2'b0, (i_cfg.left_position < i_cfg.right_position)
                     ? i_cfg.left_position : i_cfg.right_position})
                  - $signed({3'b0, i_cfg.dead_band, 1'b0});
    assign lim_hi = $signed({2'b0, (i_cfg.left_position > i_cfg.right_position)
                     ? i_cfg.left_position : i_cfg.right_position})
                  + $signed({3'b0, i_cfg.dead_band, 1'b0});

    // segment end points; exactly one end carries the full angle
    assign lr    = i_cfg.left_position < i_cfg.right_position;
    assign below = i_pos <= i_cfg.middle_position;
    always_comb begin
        case ({lr, below})
            2'b11: begin
                xa = i_cfg.left_position;   xb = i_cfg.middle_position;
                nz_a = 1'b1; nz_neg = 1'b1;
            end
            2'b10: begin
                xa = i_cfg.middle_position; xb = i_cfg.right_position;
                nz_a = 1'b0; nz_neg = 1'b0;
            end
            2'b01: begin
                xa = i_cfg.right_position;  xb = i_cfg.middle_position;
                nz_a = 1'b1; nz_neg = 1'b0;
            end
            default: begin
                xa = i_cfg.middle_position; xb = i_cfg.left_position;
                nz_a = 1'b0; nz_neg = 1'b1;
            end
        endcase
    end
    assign swp    = xa > xb;
    assign xlo    = swp ? xb : xa;
    assign xhi    = swp ? xa : xb;
    assign nz_lo  = nz_a ^ swp;
    assign nz_val = nz_neg ? -$signed({1'b0, amax}) : $signed({1'b0, amax});

    // clamp at the ends, else distance from the zero-angle end point
    always_comb begin
        n1_clamp = 1'b0;
        n1_cval  = '0;
        n1_dist  = nz_lo ? 12'(xhi - i_pos) : 12'(i_pos - xlo);
        if (i_pos <= xlo) begin
            n1_clamp = 1'b1;
            n1_cval  = nz_lo ? nz_val : 15'sd0;
        end else if (i_pos >= xhi) begin
            n1_clamp = 1'b1;
            n1_cval  = nz_lo ? 15'sd0 : nz_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_tgt   <= 27'(tgt);
            r1_pos   <= i_pos;
            r1_csgn  <= (i_cmd == 17'sd0) ? DRV_STOP : (i_cmd[16] ? DRV_NEG : DRV_POS);
            r1_over  <= ($signed({2'b0, i_pos}) < lim_lo) || ($signed({2'b0, i_pos}) > lim_hi);
            r1_clamp <= n1_clamp;
            r1_cval  <= n1_cval;
            r1_neg   <= nz_neg;
            r1_dist  <= n1_dist;
            r1_den   <= 12'(xhi - xlo);
        end
    end

    // ---------------- stage 2: drive decision, angle numerator ----------------
    logic signed [28:0] err;
    logic [28:0]        emag, m;
    logic               eneg;
    logic signed [1:0]  bang;
    logic signed [1:0]  n2_drive;
    logic [NW-1:0]      num;

    assign err  = $signed({2'b0, r1_tgt}) - $signed({2'b0, r1_pos, 15'b0});
    assign emag = err[28] ? 29'(-err) : 29'(err);

    always_comb begin
        case (i_cfg.error_sign)
            2'b01:   begin m = emag;       eneg = err[28];                 end
            2'b11:   begin m = emag;       eneg = !err[28] && (err != 0);  end
            2'b10:   begin m = emag << 1;  eneg = !err[28] && (err != 0);  end
            default: begin m = '0;         eneg = 1'b0;                    end
        endcase
        bang = (m > {4'b0, i_cfg.dead_band, 15'b0}) ? (eneg ? DRV_NEG : DRV_POS) : DRV_STOP;
        case (i_cfg.control_mode)
            MODE_BANG: n2_drive = bang;
            MODE_OPEN: n2_drive = r1_csgn;
            default:   n2_drive = DRV_STOP;
        endcase
    end

    assign num = NW'(amax * r1_dist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else if (i_en) begin
            o_vld <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_item.drive     <= n2_drive;
            o_item.target    <= r1_tgt[26:15];
            o_item.over      <= r1_over;
            o_item.clamp     <= r1_clamp;
            o_item.clamp_val <= r1_cval;
            o_item.neg       <= r1_neg;
            o_div.num        <= num;
            o_div.den        <= r1_den;
            o_div.rem        <= num[NW-1:QW];
            o_div.quo        <= '0;
        end
    end

endmodule

// ===== hdl/sbbs_div.sv =====
module sbbs_div
    import sbbs_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_vld,
    input  t_item         i_item,
    input  t_div          i_div,
    output logic          o_vld,
    output t_item         o_item,
    output logic [QW-1:0] o_quo
);

    // one quotient bit per stage, restoring
    logic  r_vld  [QW];
    t_item r_item [QW];
    t_div  r_div  [QW];

    for (genvar j = 0; j < QW; j++) begin : g_stage
        localparam int unsigned B = QW - 1 - j;
        logic  s_vld;
        t_item s_item;
        t_div  s_div;
        t_div  n_div;
        logic [12:0] t;
        logic        ge;

        if (j == 0) begin : g_first
            assign s_vld  = i_vld;
            assign s_item = i_item;
            assign s_div  = i_div;
        end else begin : g_next
            assign s_vld  = r_vld[j-1];
            assign s_item = r_item[j-1];
            assign s_div  = r_div[j-1];
        end

        assign t  = {s_div.rem, s_div.num[B]};
        assign ge = t >= {1'b0, s_div.den};
        always_comb begin
            n_div        = s_div;
            n_div.rem    = ge ? 12'(t - {1'b0, s_div.den}) : t[11:0];
            n_div.quo[B] = ge;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j] <= 1'b0;
            end else if (i_en) begin
                r_vld[j] <= s_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[j] <= s_item;
                r_div[j]  <= n_div;
            end
        end
    end

    assign o_vld  = r_vld[QW-1];
    assign o_item = r_item[QW-1];
    assign o_quo  = r_div[QW-1].quo;

endmodule

// ===== hdl/steering_bang_bang_servo.sv =====
// Steering servo: bang-bang or open-loop motor drive plus angle readout.
// Input channel (i_s_axis_*): one item per handshake carrying a steering
// command (signed, 32768 = +1.0 right) and a 12-bit position sample.
// Output channel (o_m_axis_*): one item per input item, in order, with
// motor drive, target position, angle in centidegrees and an over-limit flag.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_addr
// (mode, error sign, max angle, left/right/middle points, deadband); write
// only while no item is in flight.
// Pipeline: two front stages (target product, then drive decision and
// angle numerator), 14 divider stages giving one quotient bit each, and
// the output register. Throughput is one item per cycle while not stalled.
// Reset (synchronous, active low) empties the pipeline and loads the
// calibration defaults. When the receiver holds tready low with a result
// waiting, the whole pipeline freezes and input tready drops; nothing is
// lost or repeated.
module steering_bang_bang_servo
    import sbbs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [16:0] steer_command, [28:17] sensor_position
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [1:0] motor_drive, [13:2] target_position,
                                          // [28:14] steer_angle, [29] over_limit
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [11:0] i_cfg_data
);

    t_cfg r_cfg;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.control_mode    <= 2'd0;
            r_cfg.error_sign      <= 2'sd1;
            r_cfg.max_angle       <= 7'd35;
            r_cfg.left_position   <= 12'd1465;
            r_cfg.right_position  <= 12'd235;
            r_cfg.middle_position <= 12'd890;
            r_cfg.dead_band       <= 10'd30;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CONTROL_MODE:    r_cfg.control_mode    <= i_cfg_data[1:0];
                CFG_ERROR_SIGN:      r_cfg.error_sign      <= i_cfg_data[1:0];
                CFG_MAX_ANGLE:       r_cfg.max_angle       <= i_cfg_data[6:0];
                CFG_LEFT_POSITION:   r_cfg.left_position   <= i_cfg_data;
                CFG_RIGHT_POSITION:  r_cfg.right_position  <= i_cfg_data;
                CFG_MIDDLE_POSITION: r_cfg.middle_position <= i_cfg_data;
                CFG_DEAD_BAND:       r_cfg.dead_band       <= i_cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // pipeline advances unless a result is waiting on a stalled receiver
    logic en;
    assign en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    logic          f_vld, d_vld;
    t_item         f_item, d_item;
    t_div          f_div;
    logic [QW-1:0] d_quo;

    sbbs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (i_s_axis_tvalid),
        .i_cmd   ($signed(i_s_axis_tdata[16:0])),
        .i_pos   (i_s_axis_tdata[28:17]),
        .i_cfg   (r_cfg),
        .o_vld   (f_vld),
        .o_item  (f_item),
        .o_div   (f_div)
    );

    sbbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (f_vld),
        .i_item  (f_item),
        .i_div   (f_div),
        .o_vld   (d_vld),
        .o_item  (d_item),
        .o_quo   (d_quo)
    );

    // output register: apply sign to quotient or take the clamped angle
    logic               r_out_vld;
    logic [31:0]        r_out_data;
    logic signed [14:0] angle;

    assign angle = d_item.clamp ? d_item.clamp_val
                 : (d_item.neg ? -$signed({1'b0, d_quo}) : $signed({1'b0, d_quo}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_data <= {2'b0, d_item.over, angle, d_item.target, d_item.drive};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

    // checks; the 7-bit angle limit allows up to 127 degrees
    a_drive_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[1:0] != 2'b10))
        else $error("motor drive out of range");

    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> ($signed(o_m_axis_tdata[28:14]) <= 15'sd12700 &&
                             $signed(o_m_axis_tdata[28:14]) >= -15'sd12700))
        else $error("steering angle out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_m_axis_tvalid)
        else $error("result present right after reset");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    import sbbs_pkg::*;

    localparam int LATENCY   = 17;
    localparam int N_RANDOM  = 750;
    localparam int CYCLE_CAP = 400000;

    typedef struct packed {
        logic signed [1:0]  drive;
        logic [11:0]        target;
        logic signed [14:0] angle;
        logic               over;
    } t_servo_out;

    // one row of the directed table; check_known marks a typed-in result
    typedef struct {
        logic signed [16:0] cmd;
        logic [11:0]        pos;
        bit                 check_known;
        t_servo_out         known;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;   // [16:0] steer_command, [28:17] sensor_position
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;   // [1:0] motor_drive, [13:2] target_position,
                                   // [28:14] steer_angle, [29] over_limit
    logic        i_cfg_we;
    logic [2:0]  i_cfg_addr;
    logic [11:0] i_cfg_data;

    steering_bang_bang_servo dut (.*);

    // shadow copy of the calibration registers
    logic [1:0]        sh_mode;
    logic signed [1:0] sh_esign;
    logic [6:0]        sh_maxang;
    logic [11:0]       sh_left, sh_right, sh_mid;
    logic [9:0]        sh_band;

    t_servo_out servo_q[$];
    int         n_errors;
    int         n_items;
    int         n_results;
    longint     cycles;
    bit         fast_phase;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("timeout after %0d cycles", cycles);
            $display("[steering_bang_bang_servo] ERROR");
            $finish;
        end
    end

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch in %s at result %0d: got %0d, want %0d",
                 what, n_results, got, want);
        n_errors++;
    endtask

    // clamped interpolation, quotient truncated toward zero
    function automatic longint lerp_trunc(longint ylo, longint yhi, longint x,
                                          longint xlo, longint xhi);
        longint t;
        if (xlo > xhi) begin
            t = xlo; xlo = xhi; xhi = t;
            t = ylo; ylo = yhi; yhi = t;
        end
        if (x <= xlo) return ylo;
        if (x >= xhi) return yhi;
        return (ylo * (xhi - x) + yhi * (x - xlo)) / (xhi - xlo);
    endfunction

    function automatic t_servo_out servo_predict(logic signed [16:0] cmd_f, logic [11:0] pos_f);
        longint cmd, pos, tgt, lo, hi, err, mag, amax, ang, lp, rp, mp, db;
        t_servo_out r;
        cmd = cmd_f; pos = pos_f;
        lp = sh_left; rp = sh_right; mp = sh_mid; db = sh_band;
        if (cmd >= 0)
            tgt = (cmd >= 32768) ? rp * 32768 : mp * 32768 + cmd * (rp - mp);
        else
            tgt = (cmd <= -32768) ? lp * 32768 : lp * 32768 + (cmd + 32768) * (mp - lp);
        lo = ((lp < rp) ? lp : rp) - 2 * db;
        hi = ((lp > rp) ? lp : rp) + 2 * db;
        r.over = (pos < lo) || (pos > hi);
        r.drive = DRV_STOP;
        if (sh_mode == MODE_BANG) begin
            err = longint'(sh_esign) * (tgt - pos * 32768);
            mag = (err < 0) ? -err : err;
            if (mag > db * 32768) r.drive = (err < 0) ? DRV_NEG : DRV_POS;
        end else if (sh_mode == MODE_OPEN) begin
            r.drive = (cmd > 0) ? DRV_POS : ((cmd < 0) ? DRV_NEG : DRV_STOP);
        end
        amax = longint'(sh_maxang) * 100;
        if (lp < rp)
            ang = (pos <= mp) ? lerp_trunc(-amax, 0, pos, lp, mp)
                              : lerp_trunc(0, amax, pos, mp, rp);
        else
            ang = (pos <= mp) ? lerp_trunc(amax, 0, pos, rp, mp)
                              : lerp_trunc(0, -amax, pos, mp, lp);
        r.target = tgt[26:15];
        r.angle  = ang[14:0];
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        if (fast_phase) return 0;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return 0;
            4, 5, 6:    return 1;
            7, 8:       return $urandom_range(2, 4);
            default:    return $urandom_range(5, 30);
        endcase
    endfunction

    // one register write, then write enable low again before returning
    task automatic cfg_write(input t_cfg_idx idx, input logic [11:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_CONTROL_MODE:    sh_mode   = val[1:0];
            CFG_ERROR_SIGN:      sh_esign  = val[1:0];
            CFG_MAX_ANGLE:       sh_maxang = val[6:0];
            CFG_LEFT_POSITION:   sh_left   = val;
            CFG_RIGHT_POSITION:  sh_right  = val;
            CFG_MIDDLE_POSITION: sh_mid    = val;
            default:             sh_band   = val[9:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_all(input logic [1:0] md, input logic [1:0] es, input logic [6:0] ma,
                           input logic [11:0] lp, input logic [11:0] rp,
                           input logic [11:0] mp, input logic [9:0] db);
        cfg_write(CFG_CONTROL_MODE, 12'(md));
        cfg_write(CFG_ERROR_SIGN, 12'(es));
        cfg_write(CFG_MAX_ANGLE, 12'(ma));
        cfg_write(CFG_LEFT_POSITION, lp);
        cfg_write(CFG_RIGHT_POSITION, rp);
        cfg_write(CFG_MIDDLE_POSITION, mp);
        cfg_write(CFG_DEAD_BAND, 12'(db));
    endtask

    // called at a falling edge; holds tvalid until the item is taken,
    // and leaves it high for a following item with no gap
    task automatic send_item(input logic signed [16:0] cmd, input logic [11:0] pos);
        int g;
        g = gap_len();
        if (g != 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {3'b0, pos, cmd};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        n_items++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (servo_q.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 3) @(negedge i_clk);
    endtask

    // input monitor: expectation pushed as the item is taken
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            servo_q.push_back(servo_predict(i_s_axis_tdata[16:0], i_s_axis_tdata[28:17]));
    end

    // result checker
    always @(posedge i_clk) begin
        t_servo_out w, g;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            g = {o_m_axis_tdata[1:0], o_m_axis_tdata[13:2], o_m_axis_tdata[28:14],
                 o_m_axis_tdata[29]};
            if (servo_q.size() == 0) begin
                report("unexpected result", longint'(o_m_axis_tdata), 0);
            end else begin
                w = servo_q.pop_front();
                if (g.drive !== w.drive)   report("motor_drive", g.drive, w.drive);
                if (g.target !== w.target) report("target_position", g.target, w.target);
                if (g.angle !== w.angle)   report("steer_angle", g.angle, w.angle);
                if (g.over !== w.over)     report("over_limit", g.over, w.over);
            end
            n_results++;
        end
    end

    // receiver stalls
    initial begin
        int g;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (fast_phase) begin
                i_m_axis_tready <= 1'b1;
            end else begin
                g = gap_len();
                if (g != 0) begin
                    i_m_axis_tready <= 1'b0;
                    repeat (g) @(negedge i_clk);
                end
                i_m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
    end

    t_row rows[$];

    function automatic t_row mk(logic signed [16:0] c, logic [11:0] p);
        t_row r;
        r.cmd = c; r.pos = p; r.check_known = 1'b0; r.known = '0;
        return r;
    endfunction

    function automatic t_row mkk(logic signed [16:0] c, logic [11:0] p, t_servo_out k);
        t_row r;
        r = mk(c, p);
        r.check_known = 1'b1; r.known = k;
        return r;
    endfunction

    initial begin
        logic [11:0] a, b, m;
        int mode_pick;
        cycles = 0; n_errors = 0; n_items = 0; n_results = 0; fast_phase = 1'b0;
        i_rst_n = 1'b0; i_s_axis_tvalid = 1'b0; i_s_axis_tdata = '0;
        i_cfg_we = 1'b0; i_cfg_addr = '0; i_cfg_data = '0;
        sh_mode = MODE_BANG; sh_esign = 2'sd1; sh_maxang = 7'd35;
        sh_left = 12'd1465; sh_right = 12'd235; sh_mid = 12'd890; sh_band = 10'd30;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed part under reset calibration: ends of command and sample
        rows.push_back(mkk(17'sd0, 12'd890, '{DRV_STOP, 12'd890, 15'sd0, 1'b0}));
        rows.push_back(mkk(17'sd32768, 12'd235, '{DRV_STOP, 12'd235, 15'sd3500, 1'b0}));
        rows.push_back(mkk(-17'sd32768, 12'd1465, '{DRV_STOP, 12'd1465, -15'sd3500, 1'b0}));
        rows.push_back(mkk(-17'sd65536, 12'd4095, '{DRV_NEG, 12'd1465, -15'sd3500, 1'b1}));
        rows.push_back(mkk(17'sd65535, 12'd0, '{DRV_POS, 12'd235, 15'sd3500, 1'b1}));
        rows.push_back(mk(17'sd16384, 12'd500));
        rows.push_back(mk(-17'sd16384, 12'd1200));
        rows.push_back(mk(17'sd1, 12'd891));
        rows.push_back(mk(-17'sd1, 12'd889));
        rows.push_back(mk(17'sd32767, 12'd174));
        rows.push_back(mk(-17'sd32767, 12'd1526));
        rows.push_back(mk(17'sd0, 12'd920));
        rows.push_back(mk(17'sd0, 12'd921));
        rows.push_back(mk(17'sd0, 12'd859));
        rows.push_back(mk(17'sd100, 12'd2730));
        foreach (rows[k]) begin
            if (rows[k].check_known)
                if (servo_predict(rows[k].cmd, rows[k].pos) !== rows[k].known)
                    report("table row", longint'(servo_predict(rows[k].cmd, rows[k].pos)),
                           longint'(rows[k].known));
            send_item(rows[k].cmd, rows[k].pos);
        end
        drain();

        // other modes and reversed polarity, equal points and extreme registers
        set_all(MODE_OPEN, 2'b11, 7'd90, 12'd0, 12'd4095, 12'd2048, 10'd1023);
        foreach (rows[k]) send_item(rows[k].cmd, rows[k].pos);
        drain();
        set_all(MODE_PID, 2'b10, 7'd0, 12'd4095, 12'd0, 12'd4095, 10'd0);
        foreach (rows[k]) send_item(rows[k].cmd, rows[k].pos);
        drain();
        set_all(MODE_OTHER, 2'b00, 7'd127, 12'd700, 12'd700, 12'd700, 10'd512);
        foreach (rows[k]) send_item(rows[k].cmd, rows[k].pos);
        drain();

        // random phases, each with fresh calibration
        for (int ph = 0; ph < 15; ph++) begin
            fast_phase = (ph % 5 == 4);
            a = 12'($urandom_range(0, 4095)); b = 12'($urandom_range(0, 4095));
            m = (a < b) ? 12'($urandom_range(a, b)) : 12'($urandom_range(b, a));
            if ($urandom_range(0, 5) == 0) m = 12'($urandom_range(0, 4095));
            mode_pick = ($urandom_range(0, 9) < 6) ? 0 : $urandom_range(1, 3);
            set_all(2'(mode_pick), 2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)),
                    a, b, m,
                    ($urandom_range(0, 3) == 0) ? 10'($urandom_range(0, 1023))
                                                : 10'($urandom_range(0, 60)));
            for (int n = 0; n < N_RANDOM / 15; n++) begin
                logic signed [16:0] c;
                logic [11:0] p;
                c = 17'($urandom);
                if ($urandom_range(0, 3) != 0) c = 17'($urandom_range(0, 65536) - 32768);
                p = 12'($urandom);
                if ($urandom_range(0, 2) != 0) p = (a < b) ? 12'($urandom_range(a, b))
                                                           : 12'($urandom_range(b, a));
                send_item(c, p);
            end
            drain();
        end

        $display("sent %0d items over 19 calibration settings, checked %0d results",
                 n_items, n_results);
        if (n_errors == 0) begin
            $display("[steering_bang_bang_servo] OK");
        end else begin
            $display("%0d mismatches", n_errors);
            $display("[steering_bang_bang_servo] ERROR");
        end
        $finish;
    end

endmodule
